>>> hdl/ppp_pkg.sv
// Package for the parcel priority pipeline: depths, widths, op and status codes.
// No dependencies.
package ppp_pkg;
  localparam int INTAKE_DEPTH = 16;
  localparam int SORT_DEPTH   = 16;
  localparam int FIFO_DEPTH   = 16;
  localparam int IW = $clog2(INTAKE_DEPTH);
  localparam int SW = $clog2(SORT_DEPTH);
  localparam int FW = $clog2(FIFO_DEPTH);
  localparam int ENTRY_W = 24;

  typedef enum logic [1:0] {
    OP_INTAKE   = 2'd0,
    OP_SORT     = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_DELIVER  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_IN_SCAN, S_SR_RD, S_SR_CHK, S_SI_RD, S_SI_CHK, S_SH_RD, S_SH_WR,
    S_SI_PUT, S_DI_RD, S_DI_WR, S_DE_RD, S_DE_DONE, S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] receipt_in;
    logic [7:0]  days_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] receipt_out;
    logic [7:0]  days_out;
    logic [4:0]  queue_position;
    logic [15:0] delivered_count;
  } rsp_t;
endpackage

>>> hdl/ppp_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ppp_pkg.
interface ppp_req_if;
  import ppp_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppp_rsp_if;
  import ppp_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/parcel_priority_pipeline.sv
// Top level of the parcel priority pipeline: sequencer over three RAMs.
// Depends on ppp_pkg, ppp_if and ppp_ram.
//
//  channel | dir | payload
//  req     | in  | op, receipt_in, days_in
//  rsp     | out | status, receipt_out, days_out, queue_position, delivered_count
//
// One word at a time. Intake does a valid-bit scan; sort does a receipt search, then
// a read/compare walk and a shift walk over the sorted RAM, one port access each.
// The result sits in an output register; a new word is taken once it is taken.
// Reset is synchronous, no sweep.
module parcel_priority_pipeline (
  input logic clk,
  input logic rst,
  ppp_req_if.sink   req,
  ppp_rsp_if.source rsp
);
  import ppp_pkg::*;

  state_t state, state_next;
  req_t   cur;
  logic [INTAKE_DEPTH-1:0] intake_valid;
  logic [IW:0] idx;
  logic [SW:0] pos, shp;
  logic [SW:0] sorted_count;
  logic [FW-1:0] fifo_head, fifo_tail;
  logic [FW:0] fifo_count;
  logic [15:0] next_receipt, delivered_total;
  logic [7:0] found_days;
  rsp_t out_r;

  // intake RAM: receipt and days
  logic in_we; logic [IW-1:0] in_wa, in_ra; logic [ENTRY_W-1:0] in_wd, in_rd;
  logic so_we; logic [SW-1:0] so_wa, so_ra; logic [ENTRY_W-1:0] so_wd, so_rd;
  logic fi_we; logic [FW-1:0] fi_wa, fi_ra; logic [ENTRY_W-1:0] fi_wd, fi_rd;

  ppp_ram #(.WIDTH(ENTRY_W), .DEPTH(INTAKE_DEPTH)) u_intake (
    .clk(clk), .we(in_we), .waddr(in_wa), .wdata(in_wd), .raddr(in_ra), .rdata(in_rd));
  ppp_ram #(.WIDTH(ENTRY_W), .DEPTH(SORT_DEPTH)) u_sorted (
    .clk(clk), .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
  ppp_ram #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .we(fi_we), .waddr(fi_wa), .wdata(fi_wd), .raddr(fi_ra), .rdata(fi_rd));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = out_r;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid) begin
        case (op_t'(req.data.op))
          OP_INTAKE:   state_next = S_IN_SCAN;
          OP_SORT:     state_next = S_SR_RD;
          OP_DISPATCH: state_next = S_DI_RD;
          default:     state_next = S_DE_RD;
        endcase
      end
      S_IN_SCAN: if (idx == IW'(0) + (IW+1)'(INTAKE_DEPTH) ||
                     !intake_valid[idx[IW-1:0]]) state_next = S_OUT;
      S_SR_RD: state_next = (idx == (IW+1)'(INTAKE_DEPTH)) ? S_OUT : S_SR_CHK;
      S_SR_CHK: begin
        if (intake_valid[idx[IW-1:0]] && in_rd[23:8] == cur.receipt_in)
          state_next = (sorted_count >= (SW+1)'(SORT_DEPTH)) ? S_OUT : S_SI_RD;
        else state_next = S_SR_RD;
      end
      S_SI_RD: state_next = (pos == sorted_count) ? S_SH_RD : S_SI_CHK;
      S_SI_CHK: state_next = (so_rd[7:0] >= found_days) ? S_SI_RD : S_SH_RD;
      S_SH_RD: state_next = (shp == pos) ? S_SI_PUT : S_SH_WR;
      S_SH_WR: state_next = S_SH_RD;
      S_SI_PUT: state_next = S_OUT;
      S_DI_RD: state_next = (sorted_count == '0 || fifo_count >= (FW+1)'(FIFO_DEPTH)) ?
                 ((sorted_count == '0) ? S_OUT : S_DI_WR) : S_DI_WR;
      S_DI_WR: state_next = S_OUT;
      S_DE_RD: state_next = (fifo_count == '0) ? S_OUT : S_DE_DONE;
      S_DE_DONE: state_next = S_OUT;
      S_OUT: if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM port controls
  always_comb begin
    in_we = 1'b0; in_wa = idx[IW-1:0]; in_wd = {next_receipt, cur.days_in};
    in_ra = idx[IW-1:0];
    so_we = 1'b0; so_wa = shp[SW-1:0]; so_wd = so_rd;
    so_ra = pos[SW-1:0];
    fi_we = 1'b0; fi_wa = fifo_tail; fi_wd = so_rd; fi_ra = fifo_head;
    case (state)
      S_IN_SCAN: in_we = (idx != (IW+1)'(INTAKE_DEPTH)) && !intake_valid[idx[IW-1:0]];
      S_SH_RD: so_ra = SW'(shp - 1'b1);
      S_SH_WR: begin so_we = 1'b1; so_wd = so_rd; end
      S_SI_PUT: begin so_we = 1'b1; so_wa = pos[SW-1:0];
        so_wd = {cur.receipt_in, found_days}; end
      S_DI_RD: so_ra = SW'(sorted_count - 1'b1);
      S_DI_WR: fi_we = (fifo_count < (FW+1)'(FIFO_DEPTH));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      intake_valid <= '0;
      sorted_count <= '0;
      fifo_head <= '0; fifo_tail <= '0; fifo_count <= '0;
      next_receipt <= 16'd1;
      delivered_total <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IN_SCAN: if (idx != (IW+1)'(INTAKE_DEPTH) && !intake_valid[idx[IW-1:0]]) begin
          intake_valid[idx[IW-1:0]] <= 1'b1;
          next_receipt <= next_receipt + 16'd1;
        end
        S_SR_CHK: if (intake_valid[idx[IW-1:0]] && in_rd[23:8] == cur.receipt_in &&
                      sorted_count < (SW+1)'(SORT_DEPTH))
          intake_valid[idx[IW-1:0]] <= 1'b0;
        S_SI_PUT: sorted_count <= sorted_count + 1'b1;
        S_DI_WR: if (fifo_count < (FW+1)'(FIFO_DEPTH)) begin
          sorted_count <= sorted_count - 1'b1;
          fifo_tail <= (fifo_tail == FW'(FIFO_DEPTH - 1)) ? '0 : fifo_tail + 1'b1;
          fifo_count <= fifo_count + 1'b1;
        end
        S_DE_RD: if (fifo_count != '0) begin
          fifo_head <= (fifo_head == FW'(FIFO_DEPTH - 1)) ? '0 : fifo_head + 1'b1;
          fifo_count <= fifo_count - 1'b1;
          if (delivered_total != 16'hFFFF) delivered_total <= delivered_total + 16'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= req.data; idx <= '0; pos <= '0;
        out_r <= '0;
      end
      S_IN_SCAN: begin
        if (idx == (IW+1)'(INTAKE_DEPTH)) begin
          out_r.status <= ST_FULL;
        end else if (!intake_valid[idx[IW-1:0]]) begin
          out_r.status <= ST_OK;
          out_r.receipt_out <= next_receipt; out_r.days_out <= cur.days_in;
        end else idx <= idx + 1'b1;
      end
      S_SR_RD: begin
        out_r.receipt_out <= cur.receipt_in;
        out_r.status <= ST_NOTFOUND;
      end
      S_SR_CHK: begin
        if (intake_valid[idx[IW-1:0]] && in_rd[23:8] == cur.receipt_in) begin
          found_days <= in_rd[7:0];
          out_r.days_out <= in_rd[7:0];
          out_r.status <= (sorted_count >= (SW+1)'(SORT_DEPTH)) ? ST_FULL : ST_OK;
          shp <= sorted_count;
        end else idx <= idx + 1'b1;
      end
      S_SI_CHK: if (so_rd[7:0] >= found_days) pos <= pos + 1'b1;
      S_SH_WR: shp <= shp - 1'b1;
      S_DI_RD: if (sorted_count == '0) out_r.status <= ST_EMPTY;
      S_DI_WR: begin
        out_r.receipt_out <= so_rd[23:8]; out_r.days_out <= so_rd[7:0];
        if (fifo_count >= (FW+1)'(FIFO_DEPTH)) out_r.status <= ST_FULL;
        else out_r.queue_position <= 5'(fifo_count + 1'b1);
      end
      S_DE_RD: if (fifo_count == '0) out_r.status <= ST_EMPTY;
      S_DE_DONE: begin
        out_r.receipt_out <= fi_rd[23:8]; out_r.days_out <= fi_rd[7:0];
      end
      default: ;
    endcase
    if (state != S_IDLE && state != S_OUT) out_r.delivered_count <= delivered_total;
  end
endmodule

>>> hdl/ppp_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module ppp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> tb/sv/ppp_checker.sv
`timescale 1ns / 1ps
// Checker for the parcel priority pipeline: watches the request and response channels,
// keeps its own copy of the three stores, and counts mismatches. Depends on ppp_pkg.
module ppp_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_ready,
  input  ppp_pkg::req_t   req_data,
  input  logic            rsp_valid,
  input  logic            rsp_ready,
  input  ppp_pkg::rsp_t   rsp_data,
  output int              errors,
  output int              pending
);
  import ppp_pkg::*;

  logic        in_used [INTAKE_DEPTH];
  logic [15:0] in_rcpt [INTAKE_DEPTH];
  logic [7:0]  in_days [INTAKE_DEPTH];
  logic [23:0] ranked [SORT_DEPTH];
  int          ranked_n;
  logic [23:0] line_q [$];
  logic [15:0] next_rcpt;
  logic [15:0] shipped;
  rsp_t        owed [$];

  // Compute the response a request word should produce and update the copy.
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int i;
    int pos;
    logic [23:0] e;
    o = '0;
    case (op_t'(r.op))
      OP_INTAKE: begin
        for (i = 0; i < INTAKE_DEPTH && in_used[i]; i++) ;
        if (i >= INTAKE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          in_used[i] = 1'b1;
          in_rcpt[i] = next_rcpt;
          in_days[i] = r.days_in;
          o.receipt_out = next_rcpt;
          o.days_out = r.days_in;
          next_rcpt = next_rcpt + 16'd1;
        end
      end
      OP_SORT: begin
        for (i = 0; i < INTAKE_DEPTH; i++)
          if (in_used[i] && in_rcpt[i] == r.receipt_in) break;
        o.receipt_out = r.receipt_in;
        if (i >= INTAKE_DEPTH) begin
          o.status = ST_NOTFOUND;
        end else begin
          o.days_out = in_days[i];
          if (ranked_n >= SORT_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            // Insert after every entry with equal or more days.
            pos = 0;
            while (pos < ranked_n && ranked[pos][7:0] >= in_days[i]) pos++;
            for (int k = ranked_n; k > pos; k--) ranked[k] = ranked[k-1];
            ranked[pos] = {r.receipt_in, in_days[i]};
            ranked_n++;
            in_used[i] = 1'b0;
          end
        end
      end
      OP_DISPATCH: begin
        if (ranked_n == 0) begin
          o.status = ST_EMPTY;
        end else begin
          e = ranked[ranked_n-1];
          o.receipt_out = e[23:8];
          o.days_out = e[7:0];
          if (line_q.size() >= FIFO_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            ranked_n--;
            line_q.push_back(e);
            o.queue_position = 5'(line_q.size());
          end
        end
      end
      default: begin
        if (line_q.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          e = line_q.pop_front();
          o.receipt_out = e[23:8];
          o.days_out = e[7:0];
          if (shipped != 16'hFFFF) shipped = shipped + 16'd1;
        end
      end
    endcase
    o.delivered_count = shipped;
    return o;
  endfunction

  assign pending = owed.size();

  always @(posedge clk) begin
    rsp_t x;
    if (rst) begin
      for (int i = 0; i < INTAKE_DEPTH; i++) in_used[i] = 1'b0;
      ranked_n  = 0;
      line_q.delete();
      owed.delete();
      next_rcpt = 16'd1;
      shipped   = 16'd0;
      errors   <= 0;
    end else begin
      // Compare the response word first, then predict the accepted request.
      if (rsp_valid && rsp_ready) begin
        if (owed.size() == 0) begin
          $display("%0t: unexpected response %p", $time, rsp_data);
          errors <= errors + 1;
        end else begin
          x = owed.pop_front();
          if (x !== rsp_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, x, rsp_data);
            errors <= errors + 1;
          end
        end
      end
      if (req_valid && req_ready) owed.push_back(apply_request(req_data));
    end
  end
endmodule

>>> tb/sv/parcel_priority_pipeline_tb.sv
`timescale 1ns / 1ps
// Testbench top for the parcel priority pipeline: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on ppp_pkg, ppp_if, ppp_checker.
module parcel_priority_pipeline_tb;
  import ppp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   send_idle;
  int   take_stall;
  logic [15:0] last_rcpt;

  ppp_req_if req ();
  ppp_rsp_if rsp ();

  parcel_priority_pipeline dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  ppp_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
    .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    rsp.ready = 1'b0;
  end

  // Stall the response side at the phase's rate.
  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= take_stall);
  end

  // Hold the word until accepted, with random idle cycles before it.
  task automatic send_word(op_t op, logic [15:0] rcpt, logic [7:0] days);
    if ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= '{op: op, receipt_in: rcpt, days_in: days};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Mostly live receipts, some stale or random ones.
  task automatic random_word(int bias);
    int pick;
    logic [15:0] r;
    pick = $urandom_range(99);
    r = last_rcpt - 16'($urandom_range(20));
    if ($urandom_range(9) == 0) r = 16'($urandom);
    if (pick < bias) begin
      send_word(OP_INTAKE, 16'($urandom), 8'($urandom));
      last_rcpt = last_rcpt + 1;
    end else if (pick < bias + 30) begin
      send_word(OP_SORT, r, 8'($urandom));
    end else if (pick < bias + 55) begin
      send_word(OP_DISPATCH, 16'($urandom), 8'($urandom));
    end else begin
      send_word(OP_DELIVER, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    send_idle = 0;
    take_stall = 0;
    last_rcpt = 16'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty sources, absent receipt, extremes of days, ties, fills.
    send_word(OP_DISPATCH, 16'hFFFF, 8'hFF);
    send_word(OP_DELIVER, 16'h0000, 8'h00);
    send_word(OP_SORT, 16'h0001, 8'h00);
    send_word(OP_INTAKE, 16'hFFFF, 8'h00);
    send_word(OP_INTAKE, 16'h0000, 8'hFF);
    send_word(OP_INTAKE, 16'h0000, 8'hFF);
    send_word(OP_SORT, 16'd2, 8'h00);
    send_word(OP_SORT, 16'd3, 8'h00);
    send_word(OP_SORT, 16'd1, 8'h00);
    send_word(OP_SORT, 16'hFFFF, 8'h00);
    send_word(OP_DISPATCH, 16'd0, 8'h00);
    send_word(OP_DISPATCH, 16'd0, 8'h00);
    send_word(OP_DELIVER, 16'd0, 8'h00);
    for (int i = 0; i < 17; i++) send_word(OP_INTAKE, 16'd0, 8'($urandom_range(3)));
    last_rcpt = 16'd19;
    // Phases: no idling, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 79 : (ph == 3) ? 38 : 0;
      take_stall = (ph == 2) ? 79 : (ph == 3) ? 38 : 0;
      for (int n = 0; n < 150; n++) random_word((n % 60 < 30) ? 35 : 10);
    end
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up after a generous fixed time.
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
